[src/htos_pkg.sv]
// ----------------------------------------------------------------------------
// htos_pkg: shared types and constants for hit time order statistics
// Command codes, stream widths, result field offsets and the
// controller-to-datapath command group.
// ----------------------------------------------------------------------------
package htos_pkg;

	localparam int TIME_W = 32;
	localparam int QIDX_W = 6;
	localparam int HCNT_W = 7;
	localparam int CMD_W  = 2;
	localparam int DIV_STEPS = 32;

	// input item command codes
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// input tdata: time_value, query_index, padded to bytes
	localparam int IN_W = 40;

	// result tdata field offsets, lowest field first
	localparam int OFS_MIN          = 0;
	localparam int OFS_MAX          = 32;
	localparam int OFS_MEAN         = 64;
	localparam int OFS_SECOND       = 96;
	localparam int OFS_SECOND_VALID = 128;
	localparam int OFS_THIRD        = 129;
	localparam int OFS_THIRD_VALID  = 161;
	localparam int OFS_PICKED       = 162;
	localparam int OFS_PICKED_VALID = 194;
	localparam int OFS_HIT_COUNT    = 195;
	localparam int OFS_EMPTY        = 202;
	localparam int OFS_OVERFLOWED   = 203;
	localparam int OUT_USED_W       = 204;
	localparam int OUT_W            = 208;

	typedef struct packed {
		logic insert;      // insert the item's time into the sorted row
		logic clear;       // empty the store
		logic load_query;  // latch query index, cell taps, seed the divider
		logic rotate;      // rotate the sorted row by one place
		logic div_step;    // one quotient bit of the mean
		logic load_out;    // load the result register
	} htos_cmd_t;

endpackage

[src/htos_ctrl.sv]
// ----------------------------------------------------------------------------
// htos_ctrl: command sequencer
// Decodes accepted items, steps a query through the row rotation and the
// mean divider, and owns the result handshake.
// ----------------------------------------------------------------------------
module htos_ctrl import htos_pkg::*; #(
	parameter int MAX_HITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [CMD_W-1:0]     in_cmd,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	output htos_cmd_t            cmd,
	output logic [$clog2((MAX_HITS > DIV_STEPS) ? MAX_HITS : DIV_STEPS)-1:0] step
);

	localparam int STEPS = (MAX_HITS > DIV_STEPS) ? MAX_HITS : DIV_STEPS;
	localparam int KW    = $clog2(STEPS);
	localparam logic [KW-1:0] LAST_STEP = KW'(STEPS - 1);
	localparam logic [KW:0]   ROT_LIM   = (KW + 1)'(MAX_HITS);
	localparam logic [KW:0]   DIV_LIM   = (KW + 1)'(DIV_STEPS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_QUERY = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	logic [1:0]    state_q, state_d;
	logic [KW-1:0] step_q, step_d;
	logic          out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign step      = step_q;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						CMD_ADD:   cmd.insert = 1'b1;
						CMD_CLEAR: cmd.clear  = 1'b1;
						CMD_QUERY: begin
							cmd.load_query = 1'b1;
							step_d  = '0;
							state_d = ST_QUERY;
						end
						default: ;
					endcase
				end
			end
			ST_QUERY: begin
				cmd.rotate   = ({1'b0, step_q} < ROT_LIM);
				cmd.div_step = ({1'b0, step_q} < DIV_LIM);
				if (step_q == LAST_STEP) begin
					state_d = ST_DONE;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DONE: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/htos_dp.sv]
// ----------------------------------------------------------------------------
// htos_dp: datapath
// Sorted row of time cells with parallel compare-and-shift insert, running
// sum and count, bit-serial mean divider and the result register.
// ----------------------------------------------------------------------------
module htos_dp import htos_pkg::*; #(
	parameter int MAX_HITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  htos_cmd_t            cmd,
	input  logic [$clog2((MAX_HITS > DIV_STEPS) ? MAX_HITS : DIV_STEPS)-1:0] step,
	input  logic [TIME_W-1:0]    time_value,
	input  logic [QIDX_W-1:0]    query_index,
	output logic [OUT_W-1:0]     out_data
);

	localparam int STEPS = (MAX_HITS > DIV_STEPS) ? MAX_HITS : DIV_STEPS;
	localparam int KW    = $clog2(STEPS);
	localparam int CW    = $clog2(MAX_HITS + 1);
	localparam int LW    = $clog2(MAX_HITS);
	localparam int SW    = TIME_W + LW;
	localparam int XW0   = (KW > CW) ? KW : CW;
	localparam int XW    = (XW0 > QIDX_W) ? XW0 : QIDX_W;

	logic [TIME_W-1:0] cell_q [MAX_HITS];
	logic [MAX_HITS-1:0] shift_en;

	logic [CW-1:0]     count_q;
	logic [SW-1:0]     sum_q;
	logic              ovf_q;
	logic              full;

	logic [QIDX_W-1:0] qidx_q;
	logic [TIME_W-1:0] min_q, second_q, third_q, max_q, pick_q;
	logic [CW-1:0]     rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [OUT_W-1:0]  out_q;

	logic [CW:0]       div_try;
	logic              div_ge;
	logic              non_empty, second_ok, third_ok, pick_ok;
	logic [OUT_W-1:0]  out_d;

	assign full = (count_q == CW'(MAX_HITS));

	// Mark the cells that move: stored entries above the new time, plus the
	// first free cell.
	always_comb begin
		for (int i = 0; i < MAX_HITS; i++) begin
			if (CW'(i) < count_q) begin
				shift_en[i] = (cell_q[i] > time_value);
			end else begin
				shift_en[i] = (CW'(i) == count_q);
			end
		end
	end

	for (genvar g = 0; g < MAX_HITS; g++) begin : g_cell
		localparam int NXT = (g + 1) % MAX_HITS;
		if (g == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (cmd.insert && !full) begin
					if (shift_en[g]) begin
						cell_q[g] <= time_value;
					end
				end else if (cmd.rotate) begin
					cell_q[g] <= cell_q[NXT];
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (cmd.insert && !full) begin
					if (shift_en[g]) begin
						cell_q[g] <= shift_en[g-1] ? cell_q[g-1] : time_value;
					end
				end else if (cmd.rotate) begin
					cell_q[g] <= cell_q[NXT];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.insert) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SW'(time_value);
			end
		end
	end

	// restoring divide: sum < count * 2^32, so the high part seeds the remainder
	assign div_try = {rem_q, quo_q[TIME_W-1]};
	assign div_ge  = (div_try >= {1'b0, count_q});

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qidx_q   <= query_index;
			min_q    <= cell_q[0];
			second_q <= cell_q[1];
			third_q  <= cell_q[2];
			rem_q    <= CW'(sum_q[SW-1:TIME_W]);
			quo_q    <= sum_q[TIME_W-1:0];
		end else begin
			if (cmd.div_step) begin
				rem_q <= div_ge ? CW'(div_try - {1'b0, count_q}) : CW'(div_try);
				quo_q <= {quo_q[TIME_W-2:0], div_ge};
			end
			// the head cell shows sorted entry number step while rotating
			if (cmd.rotate && (XW'(step) == XW'(qidx_q))) begin
				pick_q <= cell_q[0];
			end
			if (cmd.rotate && (XW'(step) == XW'(count_q - 1'b1))) begin
				max_q <= cell_q[0];
			end
		end
	end

	assign non_empty = (count_q != '0);
	assign second_ok = (count_q > CW'(1));
	assign third_ok  = (count_q > CW'(2));
	assign pick_ok   = (XW'(qidx_q) < XW'(count_q));

	always_comb begin
		out_d = '0;
		out_d[OFS_MIN +: TIME_W]    = non_empty ? min_q : '0;
		out_d[OFS_MAX +: TIME_W]    = non_empty ? max_q : '0;
		out_d[OFS_MEAN +: TIME_W]   = non_empty ? quo_q : '0;
		out_d[OFS_SECOND +: TIME_W] = second_ok ? second_q : '0;
		out_d[OFS_SECOND_VALID]     = second_ok;
		out_d[OFS_THIRD +: TIME_W]  = third_ok ? third_q : '0;
		out_d[OFS_THIRD_VALID]      = third_ok;
		out_d[OFS_PICKED +: TIME_W] = pick_ok ? pick_q : '0;
		out_d[OFS_PICKED_VALID]     = pick_ok;
		out_d[OFS_HIT_COUNT +: HCNT_W] = HCNT_W'(count_q);
		out_d[OFS_EMPTY]            = !non_empty;
		out_d[OFS_OVERFLOWED]       = ovf_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= out_d;
		end
	end

	assign out_data = out_q;

endmodule

[src/hit_time_order_statistics.sv]
// Add, clear and unused commands act at acceptance; the next item is accepted the cycle after.
// Query: tready drops while the sorted row rotates once through its head cell, the mean divider
// produces one quotient bit per cycle, then waits for a free result register; tvalid rises then.
// Throughput: one add per cycle while no query runs; a query holds off all items until it ends.
// Reset: arst_n clears count, sum, overflow flag, sequencer and tvalid; stored times stay undefined.
// ----------------------------------------------------------------------------
// hit_time_order_statistics: photon arrival time order statistics
// Keeps arrival times of one detector channel in ascending order and reports
// min, max, truncated mean, second and third smallest and the time at a
// requested sorted position on a query.
// ----------------------------------------------------------------------------
module hit_time_order_statistics import htos_pkg::*; #(
	parameter int MAX_HITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,   // time_value[31:0], query_index[37:32], zero pad
	input  logic [CMD_W-1:0]  s_axis_tuser,   // cmd[1:0]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata    // min, max, mean, second, second_valid, third,
	                                          // third_valid, picked, picked_valid, hit_count,
	                                          // empty_flag, overflowed, zero pad
);

	localparam int STEPS = (MAX_HITS > DIV_STEPS) ? MAX_HITS : DIV_STEPS;
	localparam int KW    = $clog2(STEPS);

	htos_cmd_t     cmd;
	logic [KW-1:0] step;
	logic [OUT_W-1:0] out_data;

	// Sequencer: decodes the item's command at acceptance. An add or a clear
	// acts in the same edge; a query walks the step counter through the row
	// rotation and the divider, then waits for the result register.
	htos_ctrl #(
		.MAX_HITS (MAX_HITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd),
		.step      (step)
	);

	// Datapath: sorted cells with parallel insert, sum and count, divider and
	// the result register, which lets a new item in while a result waits.
	htos_dp #(
		.MAX_HITS (MAX_HITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.step        (step),
		.time_value  (s_axis_tdata[TIME_W-1:0]),
		.query_index (s_axis_tdata[TIME_W +: QIDX_W]),
		.out_data    (out_data)
	);

	// drive the pad bits low
	assign m_axis_tdata = {{(OUT_W - OUT_USED_W){1'b0}}, out_data[OUT_USED_W-1:0]};

endmodule

[src/htos_checker.sv]
// ----------------------------------------------------------------------------
// htos_checker: port-level checks for hit time order statistics
// Watches the stream ports and flags results that contradict the store's
// ordering or the sequencing of queries.
// ----------------------------------------------------------------------------
module htos_checker import htos_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic [CMD_W-1:0]  s_axis_tuser,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_W-1:0]  m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a query blocks further items while it runs
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY) |=> !s_axis_tready)
		else $error("item accepted during a query");

	// an empty store reports nothing valid
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OFS_EMPTY] |->
			(m_axis_tdata[OFS_HIT_COUNT +: HCNT_W] == '0) && !m_axis_tdata[OFS_PICKED_VALID]
			&& !m_axis_tdata[OFS_SECOND_VALID] && (m_axis_tdata[OFS_MIN +: TIME_W] == '0))
		else $error("empty result carries data");

	// order statistics ascend
	a_order_second: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OFS_SECOND_VALID] |->
			m_axis_tdata[OFS_MIN +: TIME_W] <= m_axis_tdata[OFS_SECOND +: TIME_W])
		else $error("second smallest below min");

	a_order_third: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OFS_THIRD_VALID] |->
			m_axis_tdata[OFS_SECOND_VALID] &&
			(m_axis_tdata[OFS_SECOND +: TIME_W] <= m_axis_tdata[OFS_THIRD +: TIME_W]))
		else $error("third smallest out of order");

endmodule

bind hit_time_order_statistics htos_checker u_htos_checker (.*);

[bench/tb_hit_time_order_statistics.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hit_time_order_statistics: self-checking bench for the hit time store
// Drives add, query, clear and unused commands on the input stream and checks
// every query result field by field against a sorted-store predictor. Both
// stream sides idle at random, and one long output hold-off backs up the block.
// ----------------------------------------------------------------------------
module tb_hit_time_order_statistics;
	import htos_pkg::*;

	localparam int HITS = 64;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1300;
	localparam int HOLD_CYCLES = 400;
	// a query holds off the input while it runs; leave margin on top of that
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT = 600000;
	localparam int REPORT_MAX = 10;

	typedef struct {
		logic [TIME_W-1:0] min_t;
		logic [TIME_W-1:0] max_t;
		logic [TIME_W-1:0] mean_t;
		logic [TIME_W-1:0] second_t;
		logic              second_v;
		logic [TIME_W-1:0] third_t;
		logic              third_v;
		logic [TIME_W-1:0] picked_t;
		logic              picked_v;
		logic [HCNT_W-1:0] count;
		logic              empty;
		logic              ovf;
	} hit_stats_t;

	// Sorted-store predictor plus queue of query results still owed by the block.
	class hit_stats_scoreboard;
		logic [TIME_W-1:0] row [HITS];
		int unsigned       count;
		longint unsigned   sum;
		bit                ovf;
		hit_stats_t        owed [$];
		int                mismatches;
		int                results_seen;

		function new();
			count = 0;
			sum = 0;
			ovf = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void note_input(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] t,
				logic [QIDX_W-1:0] q);
			int pos;
			hit_stats_t e;
			case (cmd)
				CMD_ADD: begin
					if (count >= HITS) begin
						ovf = 1;
					end else begin
						// equal times stay ahead of the newcomer
						pos = count;
						while (pos > 0 && row[pos-1] > t) begin
							row[pos] = row[pos-1];
							pos--;
						end
						row[pos] = t;
						count++;
						sum += t;
					end
				end
				CMD_CLEAR: begin
					count = 0;
					sum = 0;
					ovf = 0;
				end
				CMD_QUERY: begin
					e.min_t    = (count > 0) ? row[0] : '0;
					e.max_t    = (count > 0) ? row[count-1] : '0;
					e.mean_t   = (count > 0) ? TIME_W'(sum / 64'(count)) : '0;
					e.second_v = (count > 1);
					e.second_t = e.second_v ? row[1] : '0;
					e.third_v  = (count > 2);
					e.third_t  = e.third_v ? row[2] : '0;
					e.picked_v = (q < count);
					e.picked_t = e.picked_v ? row[q] : '0;
					e.count    = HCNT_W'(count);
					e.empty    = (count == 0);
					e.ovf      = ovf;
					owed.push_back(e);
				end
				default: begin
					// unused command: no state change, no result
				end
			endcase
		endfunction

		function void flag(string what, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] act_v);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("mismatch result %0d %s: expected %h actual %h",
					results_seen, what, exp_v, act_v);
		endfunction

		function void cmp(string what, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] act_v);
			if (act_v !== exp_v)
				flag(what, exp_v, act_v);
		endfunction

		function void check_result(logic [OUT_W-1:0] d);
			hit_stats_t e;
			results_seen++;
			if (owed.size() == 0) begin
				flag("unrequested result", '0, d[TIME_W-1:0]);
				return;
			end
			e = owed.pop_front();
			cmp("min_time",     e.min_t,    d[OFS_MIN +: TIME_W]);
			cmp("max_time",     e.max_t,    d[OFS_MAX +: TIME_W]);
			cmp("mean_time",    e.mean_t,   d[OFS_MEAN +: TIME_W]);
			cmp("second_time",  e.second_t, d[OFS_SECOND +: TIME_W]);
			cmp("second_valid", e.second_v, d[OFS_SECOND_VALID]);
			cmp("third_time",   e.third_t,  d[OFS_THIRD +: TIME_W]);
			cmp("third_valid",  e.third_v,  d[OFS_THIRD_VALID]);
			cmp("picked_time",  e.picked_t, d[OFS_PICKED +: TIME_W]);
			cmp("picked_valid", e.picked_v, d[OFS_PICKED_VALID]);
			cmp("hit_count",    e.count,    d[OFS_HIT_COUNT +: HCNT_W]);
			cmp("empty_flag",   e.empty,    d[OFS_EMPTY]);
			cmp("overflowed",   e.ovf,      d[OFS_OVERFLOWED]);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;   // time_value[31:0], query_index[37:32], zero pad
	logic [CMD_W-1:0]  s_axis_tuser = CMD_UNUSED;   // cmd[1:0]
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;   // min, max, mean, second, second_valid, third,
	                                   // third_valid, picked, picked_valid, hit_count,
	                                   // empty_flag, overflowed, zero pad

	hit_stats_scoreboard sb = new();

	int  items_sent = 0;
	int  cycle_count = 0;
	bit  tx_fast = 0;     // sender offers back to back while set
	bit  hold_req = 0;    // asks the result side for one long hold-off

	hit_time_order_statistics #(.MAX_HITS(HITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Sample both handshakes at the rising edge; settle results before noting
	// new inputs so an unrequested result is never masked by a fresh query.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(s_axis_tuser, s_axis_tdata[TIME_W-1:0],
					s_axis_tdata[TIME_W +: QIDX_W]);
		end
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: idle at random before each item, with stretches of
	// no idling, and once hold off for a long stretch when asked.
	initial begin : result_sink
		int wait_cycles;
		int since_redraw;
		bit rx_fast;
		rx_fast = 0;
		since_redraw = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				wait_cycles = HOLD_CYCLES;
			end else begin
				wait_cycles = rx_fast ? 0 : $urandom_range(0, 6);
			end
			if (wait_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (++since_redraw >= 16) begin
				since_redraw = 0;
				rx_fast = ($urandom_range(0, 2) == 0);
			end
		end
	end

	// Offer one item after a random gap and hold it until it is taken.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] t,
			logic [QIDX_W-1:0] q);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= {{(IN_W-TIME_W-QIDX_W){1'b0}}, q, t};
		s_axis_tuser  <= cmd;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// Time value in one of three flavors: any, tiny (forces ties), or near the top.
	function automatic logic [TIME_W-1:0] draw_time(int flavor);
		case (flavor)
			0: return $urandom();
			1: return $urandom_range(0, 15);
			default: return 32'hFFFF_FFFF - $urandom_range(0, 15);
		endcase
	endfunction

	// Query index: half the time up to the current fill, else anywhere.
	function automatic logic [QIDX_W-1:0] draw_index();
		int top;
		top = (sb.count < HITS) ? sb.count : HITS - 1;
		if ($urandom_range(0, 1) == 1 && top > 0)
			return QIDX_W'($urandom_range(0, top));
		return QIDX_W'($urandom_range(0, 63));
	endfunction

	initial begin : stimulus
		int sel;
		int burst;
		int flavor;
		bit hold_done;
		hold_done = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty store, single and double entries, ties, extremes,
		// out-of-range index, clear, unused command.
		send_item(CMD_QUERY,  32'hFFFF_FFFF, 6'd0);
		send_item(CMD_QUERY,  32'h0,         6'd63);
		send_item(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63);
		send_item(CMD_ADD,    32'hFFFF_FFFF, 6'd63);
		send_item(CMD_QUERY,  32'h0,         6'd0);
		send_item(CMD_ADD,    32'h0,         6'd0);
		send_item(CMD_QUERY,  32'h0,         6'd1);
		send_item(CMD_ADD,    32'hFFFF_FFFF, 6'd0);
		send_item(CMD_ADD,    32'd5,         6'd0);
		send_item(CMD_QUERY,  32'h0,         6'd3);
		send_item(CMD_QUERY,  32'h0,         6'd4);
		send_item(CMD_QUERY,  32'h0,         6'd63);
		send_item(CMD_CLEAR,  32'hFFFF_FFFF, 6'd63);
		send_item(CMD_QUERY,  32'h0,         6'd0);
		send_item(CMD_ADD,    32'd7,         6'd0);
		send_item(CMD_ADD,    32'd7,         6'd0);
		send_item(CMD_ADD,    32'd7,         6'd0);
		send_item(CMD_QUERY,  32'h0,         6'd2);
		send_item(CMD_UNUSED, 32'h0,         6'd0);
		send_item(CMD_QUERY,  32'h0,         6'd1);
		send_item(CMD_CLEAR,  32'h0,         6'd0);

		// Fill to the brim with top values (widest sum), then overrun it.
		repeat (HITS + 2) send_item(CMD_ADD, draw_time(2), draw_index());
		send_item(CMD_QUERY, 32'h0, 6'd63);
		send_item(CMD_QUERY, 32'h0, 6'd0);
		send_item(CMD_CLEAR, 32'h0, 6'd0);
		send_item(CMD_QUERY, 32'h0, 6'd0);

		// Random: mostly adds and queries, with fill bursts deep enough to reach
		// the full and overflowed states, plus clears and unused commands.
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 29) == 0)
				tx_fast = !tx_fast;
			if (!hold_done && items_sent >= ITEM_TARGET / 2) begin
				// back up the block: queries keep coming while results are held
				hold_done = 1;
				hold_req = 1;
				tx_fast = 1;
				repeat (12) send_item(CMD_QUERY, $urandom(), draw_index());
				tx_fast = 0;
			end
			sel = $urandom_range(0, 99);
			if (sel < 6) begin
				send_item(CMD_CLEAR, $urandom(), QIDX_W'($urandom_range(0, 63)));
			end else if (sel < 8) begin
				send_item(CMD_UNUSED, $urandom(), QIDX_W'($urandom_range(0, 63)));
			end else if (sel < 11) begin
				burst = $urandom_range(30, 70);
				flavor = $urandom_range(0, 2);
				repeat (burst) send_item(CMD_ADD, draw_time(flavor), draw_index());
				send_item(CMD_QUERY, $urandom(), draw_index());
			end else if (sel < 38) begin
				send_item(CMD_QUERY, $urandom(), draw_index());
			end else begin
				send_item(CMD_ADD, draw_time($urandom_range(0, 2)), draw_index());
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// Drain: every owed result must arrive, then give stray ones a chance.
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[hit_time_order_statistics.f]
src/htos_pkg.sv
src/htos_ctrl.sv
src/htos_dp.sv
src/hit_time_order_statistics.sv
src/htos_checker.sv
bench/tb_hit_time_order_statistics.sv
